// File: hw/rtl/htfr_pkg.sv
// shared types and constants of the header/tail frame receiver
`default_nettype none

package htfr_pkg;

	// longest frame in bytes, header and tail included
	localparam int FRAME_CAPACITY = 32;

	localparam int BYTE_W = 8;
	localparam int HELD_W = $clog2(FRAME_CAPACITY);
	localparam int POS_W  = 5;
	localparam int LEN_W  = 6;
	localparam int CFG_INDEX_W = 2;

	// result item tdata: position, data_byte, frame_length, padded to bytes
	localparam int RES_BITS = POS_W + BYTE_W + LEN_W;
	localparam int RES_TDATA_W = ((RES_BITS + 7) / 8) * 8;

	typedef enum logic [2:0] {
		STATUS_MISMATCH = 3'd0,
		STATUS_HEADER   = 3'd1,
		STATUS_PAYLOAD  = 3'd2,
		STATUS_COMPLETE = 3'd3,
		STATUS_OVERFLOW = 3'd4
	} htfr_status_t;

	localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FIRST  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SECOND = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TAIL_VALUE    = 2'd2;

	localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
	localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h55;
	localparam logic [BYTE_W-1:0] TAIL_VALUE_RST    = 8'h0D;

	// last position a payload byte may take; the tail still fits after it
	localparam logic [HELD_W-1:0] HELD_LAST_PAYLOAD = HELD_W'(FRAME_CAPACITY - 2);

endpackage

`default_nettype wire

// File: hw/rtl/header_tail_frame_receiver_core.sv
// top level of the header/tail frame receiver
`default_nettype none

// Deframes a received byte stream of the form header_first, header_second,
// payload bytes, tail byte. Bytes enter on the s_axis channel, one per
// transaction in tdata[7:0]. Every byte gives exactly one result transaction
// on m_axis: tuser carries the status code, tdata the position where the
// byte was stored, the echoed byte and, on the tail byte, the frame length.
// The header and tail byte values are written through the cfg channel
// (index 0 header_first, 1 header_second, 2 tail_value; index 3 ignored);
// cfg_ready is always high and writes are expected only while idle.
// The result of a byte accepted at one edge is registered and shown from
// the next cycle. Throughput is one byte per cycle; the single output
// register is the only stage, and s_axis_tready stays high as long as that
// register is empty or is being emptied in the same cycle. A stall on
// m_axis holds the result and drops s_axis_tready until it is taken.
// Reset clears the frame tracking, empties the output register and returns
// the three byte values to their defaults (0xAA, 0x55, 0x0D).
module header_tail_frame_receiver_core (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire  [7:0]                        s_axis_tdata,   // [7:0] rx_byte
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	// [4:0] position, [12:5] data_byte, [18:13] frame_length, [23:19] zero
	output logic [htfr_pkg::RES_TDATA_W-1:0]  m_axis_tdata,
	output logic [2:0]                        m_axis_tuser,   // [2:0] status
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [htfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire  [7:0]                        cfg_data
);
	import htfr_pkg::*;

	// configuration registers
	logic [BYTE_W-1:0] header_first_q;
	logic [BYTE_W-1:0] header_second_q;
	logic [BYTE_W-1:0] tail_value_q;

	// frame tracking
	logic [HELD_W-1:0] bytes_held_q;
	logic              in_frame_q;

	// result register
	logic              out_valid_q;
	htfr_status_t      status_q;
	logic [POS_W-1:0]  position_q;
	logic [BYTE_W-1:0] data_byte_q;
	logic [LEN_W-1:0]  frame_length_q;

	// next-state and result logic
	htfr_status_t      status_d;
	logic [POS_W-1:0]  position_d;
	logic [LEN_W-1:0]  frame_length_d;
	logic [HELD_W-1:0] bytes_held_d;
	logic              in_frame_d;
	logic [HELD_W:0]   length_full;
	logic              in_accept;
	logic              cfg_accept;

	assign cfg_ready     = 1'b1;
	assign cfg_accept    = cfg_valid & cfg_ready;
	// output register empty or emptied this cycle
	assign s_axis_tready = ~out_valid_q | m_axis_tready;
	assign in_accept     = s_axis_tvalid & s_axis_tready;

	assign length_full = {1'b0, bytes_held_q} + (HELD_W + 1)'(1);

	always_comb begin
		status_d       = STATUS_MISMATCH;
		position_d     = '0;
		frame_length_d = '0;
		bytes_held_d   = bytes_held_q;
		in_frame_d     = in_frame_q;
		if (!in_frame_q) begin
			// hunting for the two header bytes, position decides which
			if (s_axis_tdata == header_first_q && bytes_held_q == '0) begin
				status_d     = STATUS_HEADER;
				bytes_held_d = HELD_W'(1);
			end else if (s_axis_tdata == header_second_q &&
					bytes_held_q == HELD_W'(1)) begin
				status_d     = STATUS_HEADER;
				position_d   = POS_W'(1);
				bytes_held_d = HELD_W'(2);
				in_frame_d   = 1'b1;
			end else begin
				bytes_held_d = '0;
			end
		end else if (s_axis_tdata == tail_value_q) begin
			// tail closes the frame, tracking restarts at once
			status_d       = STATUS_COMPLETE;
			position_d     = POS_W'(bytes_held_q);
			frame_length_d = LEN_W'(length_full);
			bytes_held_d   = '0;
			in_frame_d     = 1'b0;
		end else if (bytes_held_q <= HELD_LAST_PAYLOAD) begin
			status_d     = STATUS_PAYLOAD;
			position_d   = POS_W'(bytes_held_q);
			bytes_held_d = bytes_held_q + HELD_W'(1);
		end else begin
			// no room left for this payload byte and the tail
			status_d     = STATUS_OVERFLOW;
			bytes_held_d = '0;
			in_frame_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q  <= HEADER_FIRST_RST;
			header_second_q <= HEADER_SECOND_RST;
			tail_value_q    <= TAIL_VALUE_RST;
		end else if (cfg_accept) begin
			case (cfg_index)
				REG_HEADER_FIRST:  header_first_q  <= cfg_data;
				REG_HEADER_SECOND: header_second_q <= cfg_data;
				REG_TAIL_VALUE:    tail_value_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_held_q <= '0;
			in_frame_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_accept) begin
				bytes_held_q <= bytes_held_d;
				in_frame_q   <= in_frame_d;
				out_valid_q  <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload of the result register, loaded on every accepted byte
	always_ff @(posedge clk) begin
		if (in_accept) begin
			status_q       <= status_d;
			position_q     <= position_d;
			data_byte_q    <= s_axis_tdata;
			frame_length_q <= frame_length_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = RES_TDATA_W'({frame_length_q, data_byte_q, position_q});

endmodule

`default_nettype wire

// File: hw/rtl/htfr_checker.sv
// port-level checks of the header/tail frame receiver, bound to the top level
`default_nettype none

module htfr_checker (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               s_axis_tvalid,
	input wire                               s_axis_tready,
	input wire [7:0]                         s_axis_tdata,
	input wire                               m_axis_tvalid,
	input wire                               m_axis_tready,
	input wire [htfr_pkg::RES_TDATA_W-1:0]   m_axis_tdata,
	input wire [2:0]                         m_axis_tuser
);
	import htfr_pkg::*;

	// a stalled result transaction holds its payload
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// an accepted byte shows up as the next result, echoed
	a_echo: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=>
			m_axis_tvalid && m_axis_tdata[12:5] == $past(s_axis_tdata))
		else $error("accepted byte not echoed in next result");

	// mismatch and overflow carry no position and no length
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == STATUS_MISMATCH ||
			m_axis_tuser == STATUS_OVERFLOW) |->
			m_axis_tdata[4:0] == '0 && m_axis_tdata[18:13] == '0)
		else $error("dropped byte reports position or length");

	// only a completed frame reports a length, and it covers the tail
	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(m_axis_tuser == STATUS_COMPLETE) == (m_axis_tdata[18:13] != '0))
		else $error("frame length does not match status");

endmodule

bind header_tail_frame_receiver_core htfr_checker u_htfr_checker (.*);

`default_nettype wire
